FILE: rtl/sorted_timer_queue_macros.svh
// Assertion macros for the timer queue
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH
// Assert that prop holds at every clock edge out of reset.
`define STQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that cond implies prop in the next cycle.
`define STQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned ENTRY_W = 96;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_SWEEP    = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_INVAL    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [31:0] MS_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] MS_CAP  = 32'h7FFF_FFFF;
  // rounded-up tick count at which the millisecond figure reaches 2^31
  localparam logic [63:0] MS_CAP_TICKS = 64'd21474836480000;
  // ceil(2^51 / 625) in three 14-bit limbs, low limb first
  localparam logic [13:0] RECIP_LIMB0 = 14'd9097;
  localparam logic [13:0] RECIP_LIMB1 = 14'd12661;
  localparam logic [13:0] RECIP_LIMB2 = 14'd13421;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] timeout;
    logic [62:0] now;
    logic        handle_present;
    logic [3:0]  handle_slot;
    logic [31:0] handle_gen;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_expired;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [31:0] next_ms;
    logic        last;
  } out_item_t;
endpackage

FILE: rtl/stq_if.sv
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic              valid;
  logic              ready;
  stq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stq_out_if;
  logic               valid;
  logic               ready;
  stq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sorted_timer_queue.sv
// Throughput: one item at a time; the next is taken the cycle after the final
//   result is taken. Receiver stalls hold up every command.
// Reset clears the used/canceled bits, queue length and generation counter at once.
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Sixteen one-shot timers kept in expiry order, with generation-tagged handles.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_macros.svh"

module sorted_timer_queue (
  input logic   clk,
  input logic   rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch
);
  localparam int unsigned N  = stq_pkg::TIMER_SLOTS;
  localparam int unsigned SW = stq_pkg::SLOT_W;
  localparam int unsigned CW = stq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_REG_FIND, S_REG_SCAN, S_REG_CMP, S_REG_SHIFT,
    S_CAN_RD, S_CAN_CMP, S_SW_RD, S_SW_CHK, S_SW_POP, S_DIV, S_OUT
  } state_t;

  state_t            state_r;
  stq_pkg::in_item_t cmd_r;
  stq_pkg::out_item_t res_r;
  logic              res_valid_r;
  logic [N-1:0]      used_r, canc_r;
  logic [SW-1:0]     queue_r [N];
  logic [CW-1:0]     qlen_r, pos_r;
  logic [SW-1:0]     slot_r;
  logic [31:0]       gen_ctr_r;
  logic [63:0]       when_r, quo_r;
  logic [82:0]       acc_r;
  logic [1:0]        div_cnt_r;

  // Entry RAM: {when, gen} per slot
  logic                      ram_we;
  logic [SW-1:0]             ram_waddr, ram_raddr;
  logic [stq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [63:0] rd_when;
  logic [31:0] rd_gen;

  stq_ram #(.WIDTH(stq_pkg::ENTRY_W), .DEPTH(N)) u_entry_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
  assign rd_when = ram_rdata[95:32];
  assign rd_gen  = ram_rdata[31:0];

  // Lowest free slot
  logic [SW-1:0] free_slot;
  logic          free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SW'(i);
        free_any  = 1'b1;
      end
    end
  end

  // Read address: in every reading state the slot comes from the queue or the handle
  logic [SW-1:0] pos_idx;
  assign pos_idx = pos_r[SW-1:0];
  always_comb begin
    unique case (state_r)
      S_CAN_RD: ram_raddr = cmd_r.handle_slot[SW-1:0];
      default:  ram_raddr = queue_r[pos_idx];
    endcase
  end

  assign ram_we    = (state_r == S_REG_FIND) && free_any && (qlen_r < CW'(N));
  assign ram_waddr = free_slot;
  assign ram_wdata = {when_r, gen_ctr_r + 32'd1};

  logic [63:0] sw_d;
  assign sw_d = rd_when - {1'b0, cmd_r.now};

  // Milliseconds: (ticks + 9999) / 16 times the scaled reciprocal of 625, one limb a cycle.
  // Below the cap the rounded tick count fits 45 bits, so the shifted value fits 41.
  logic [13:0] div_limb;
  logic [54:0] div_pp;
  always_comb begin
    unique case (div_cnt_r)
      2'd0:    div_limb = stq_pkg::RECIP_LIMB0;
      2'd1:    div_limb = stq_pkg::RECIP_LIMB1;
      default: div_limb = stq_pkg::RECIP_LIMB2;
    endcase
  end
  assign div_pp = 55'(quo_r[44:4]) * 55'(div_limb);

  assign in_ch.ready = (state_r == S_IDLE) && !res_valid_r;
  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r;

  logic res_take;
  assign res_take = res_valid_r && out_ch.ready;

  function automatic stq_pkg::out_item_t mk(input logic [1:0] st, input logic ex,
                                           input logic [3:0] sl, input logic [31:0] g,
                                           input logic [31:0] ms, input logic lst);
    stq_pkg::out_item_t o;
    o.status = st; o.is_expired = ex; o.slot = sl; o.gen = g; o.next_ms = ms; o.last = lst;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      used_r      <= '0;
      canc_r      <= '0;
      qlen_r      <= '0;
      gen_ctr_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd_r <= in_ch.data;
            // zero or negative timeout counts back from now
            if (in_ch.data.timeout == 64'd0 || in_ch.data.timeout[63]) begin
              when_r <= {1'b0, in_ch.data.now} - in_ch.data.timeout;
            end else begin
              when_r <= in_ch.data.timeout;
            end
            pos_r <= '0;
            unique case (in_ch.data.command)
              stq_pkg::CMD_REGISTER: state_r <= S_REG_FIND;
              stq_pkg::CMD_CANCEL: begin
                if (!in_ch.data.handle_present) begin
                  res_r <= mk(stq_pkg::ST_INVAL, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
                  res_valid_r <= 1'b1;
                  state_r <= S_OUT;
                end else if (32'(in_ch.data.handle_slot) >= N) begin
                  res_r <= mk(stq_pkg::ST_NOTFOUND, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
                  res_valid_r <= 1'b1;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_CAN_RD;
                end
              end
              stq_pkg::CMD_SWEEP: state_r <= S_SW_RD;
              default: begin
                res_r <= mk(stq_pkg::ST_INVAL, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
                res_valid_r <= 1'b1;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_REG_FIND: begin
          if (!ram_we) begin
            res_r <= mk(stq_pkg::ST_NOMEM, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
            res_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            gen_ctr_r <= gen_ctr_r + 32'd1;
            used_r[free_slot] <= 1'b1;
            canc_r[free_slot] <= 1'b0;
            slot_r <= free_slot;
            state_r <= (qlen_r == '0) ? S_REG_SHIFT : S_REG_SCAN;
          end
        end
        S_REG_SCAN: state_r <= S_REG_CMP;   // read of queue entry at pos in flight
        S_REG_CMP: begin
          // stop at first entry with when >= new when (signed)
          if ($signed(rd_when) >= $signed(when_r)) begin
            state_r <= S_REG_SHIFT;
          end else if (pos_r + CW'(1) == qlen_r) begin
            pos_r <= qlen_r;
            state_r <= S_REG_SHIFT;
          end else begin
            pos_r <= pos_r + CW'(1);
            state_r <= S_REG_SCAN;
          end
        end
        S_REG_SHIFT: begin
          // insert at pos: shift tail up by one
          for (int i = N - 1; i > 0; i--) begin
            if (CW'(i) > pos_r && CW'(i) <= qlen_r) begin
              queue_r[i] <= queue_r[i-1];
            end
          end
          queue_r[pos_idx] <= slot_r;
          qlen_r <= qlen_r + CW'(1);
          res_r <= mk(stq_pkg::ST_OK, 1'b0, 4'(slot_r), gen_ctr_r, 32'd0, 1'b1);
          res_valid_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_CAN_RD: state_r <= S_CAN_CMP;
        S_CAN_CMP: begin
          if (used_r[cmd_r.handle_slot[SW-1:0]] && rd_gen == cmd_r.handle_gen) begin
            canc_r[cmd_r.handle_slot[SW-1:0]] <= 1'b1;
            res_r <= mk(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
          end else begin
            res_r <= mk(stq_pkg::ST_NOTFOUND, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1);
          end
          res_valid_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_SW_RD: begin
          if (qlen_r == '0) begin
            // hold the final item until an expired item ahead of it is taken
            if (!res_valid_r || res_take) begin
              res_r <= mk(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, stq_pkg::MS_NONE, 1'b1);
              res_valid_r <= 1'b1;
              state_r <= S_OUT;
            end
          end else begin
            if (res_take) begin
              res_valid_r <= 1'b0;
            end
            state_r <= S_SW_CHK;  // head read in flight
          end
        end
        S_SW_CHK: begin
          if (!res_valid_r || res_take) begin
            if (canc_r[queue_r[0]]) begin
              res_valid_r <= 1'b0;
              state_r <= S_SW_POP;
            end else if (sw_d != 64'd0 && !sw_d[63]) begin
              res_valid_r <= 1'b0;
              quo_r <= sw_d + 64'd9999;
              acc_r <= '0;
              div_cnt_r <= '0;
              state_r <= S_DIV;
            end else begin
              res_r <= mk(stq_pkg::ST_OK, 1'b1, 4'(queue_r[0]), rd_gen, 32'd0, 1'b0);
              res_valid_r <= 1'b1;
              state_r <= S_SW_POP;
            end
          end
        end
        S_SW_POP: begin
          // free head and shift queue down
          if (res_take) begin
            res_valid_r <= 1'b0;
          end
          used_r[queue_r[0]] <= 1'b0;
          canc_r[queue_r[0]] <= 1'b0;
          for (int i = 0; i < N - 1; i++) begin
            queue_r[i] <= queue_r[i+1];
          end
          qlen_r <= qlen_r - CW'(1);
          state_r <= S_SW_RD;
        end
        S_DIV: begin
          // three limb products accumulate, then the quotient sits above bit 51
          if (div_cnt_r == 2'd3) begin
            if (quo_r >= stq_pkg::MS_CAP_TICKS) begin
              res_r <= mk(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, stq_pkg::MS_CAP, 1'b1);
            end else begin
              res_r <= mk(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, acc_r[82:51], 1'b1);
            end
            res_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            unique case (div_cnt_r)
              2'd0:    acc_r <= acc_r + 83'(div_pp);
              2'd1:    acc_r <= acc_r + (83'(div_pp) << 14);
              default: acc_r <= acc_r + (83'(div_pp) << 28);
            endcase
            div_cnt_r <= div_cnt_r + 2'd1;
          end
        end
        S_OUT: begin
          // hold until the final item is taken
          if (res_take) begin
            res_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `STQ_ASSERT(a_len_bound, clk, rst_n, qlen_r <= CW'(N), "queue length exceeds table")
  `STQ_ASSERT(a_ready_idle, clk, rst_n, !(in_ch.ready && state_r != S_IDLE), "ready outside idle")
  `STQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(out_ch.data), "result dropped while stalled")
  `STQ_ASSERT_NEXT(a_reg_count, clk, rst_n, state_r == S_REG_SHIFT,
                   qlen_r == $past(qlen_r) + CW'(1), "register did not grow queue")
endmodule

FILE: dv/sorted_timer_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_test
// Drives register, cancel, sweep and reserved commands into the timer table with
// random gaps and back-pressure, predicts every result item and checks them in order.
// ----------------------------------------------------------------------------
module sorted_timer_queue_test;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  sorted_timer_queue uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the timer table and its expiry-ordered queue of slots.
  logic        tbl_used     [stq_pkg::TIMER_SLOTS] = '{default: 1'b0};
  logic        tbl_canceled [stq_pkg::TIMER_SLOTS] = '{default: 1'b0};
  logic [63:0] tbl_when     [stq_pkg::TIMER_SLOTS] = '{default: 64'd0};
  logic [31:0] tbl_gen      [stq_pkg::TIMER_SLOTS] = '{default: 32'd0};
  logic [31:0] gen_count = 32'd0;
  int          order [$];

  stq_pkg::in_item_t  pending_cmds [$];
  stq_pkg::out_item_t awaited [$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        stimulus_done = 1'b0;
  int        hold_off = 0;   // cycles the receiver still refuses
  bit        stall_done = 1'b0;

  // Time base for the random part; advances so sweeps really expire timers.
  logic [62:0] clock_now = 63'd1_000_000;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic stq_pkg::out_item_t reply(input logic [1:0] st, input logic ex,
                                               input logic [3:0] s, input logic [31:0] g,
                                               input logic [31:0] ms, input logic lst);
    stq_pkg::out_item_t r;
    r.status = st; r.is_expired = ex; r.slot = s; r.gen = g;
    r.next_ms = ms; r.last = lst;
    return r;
  endfunction

  // Work out the results of one accepted command and queue them.
  task automatic predict_results(input stq_pkg::in_item_t c);
    logic [63:0] when_t, d, ms;
    int          s, pos;
    bit          waiting;
    case (c.command)
      stq_pkg::CMD_REGISTER: begin
        s = -1;
        for (int i = stq_pkg::TIMER_SLOTS - 1; i >= 0; i--) if (!tbl_used[i]) s = i;
        if (s < 0) begin
          awaited.push_back(reply(stq_pkg::ST_NOMEM, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1));
        end else begin
          // zero or negative timeout counts back from now
          if (c.timeout == 64'd0 || c.timeout[63])
            when_t = {1'b0, c.now} - c.timeout;
          else
            when_t = c.timeout;
          gen_count++;
          tbl_used[s] = 1'b1; tbl_canceled[s] = 1'b0;
          tbl_when[s] = when_t; tbl_gen[s] = gen_count;
          // newest goes ahead of equal times
          pos = order.size();
          for (int i = 0; i < order.size(); i++)
            if ($signed(tbl_when[order[i]]) >= $signed(when_t)) begin
              pos = i;
              break;
            end
          order.insert(pos, s);
          awaited.push_back(reply(stq_pkg::ST_OK, 1'b0, s[3:0], gen_count, 32'd0, 1'b1));
        end
      end
      stq_pkg::CMD_CANCEL: begin
        if (!c.handle_present)
          awaited.push_back(reply(stq_pkg::ST_INVAL, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1));
        else if (tbl_used[c.handle_slot] && tbl_gen[c.handle_slot] == c.handle_gen) begin
          tbl_canceled[c.handle_slot] = 1'b1;
          awaited.push_back(reply(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1));
        end else
          awaited.push_back(reply(stq_pkg::ST_NOTFOUND, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1));
      end
      stq_pkg::CMD_SWEEP: begin
        waiting = 1'b0;
        d = '0;
        while (order.size() > 0) begin
          s = order[0];
          if (tbl_canceled[s]) begin
            tbl_used[s] = 1'b0; tbl_canceled[s] = 1'b0;
            void'(order.pop_front());
            continue;
          end
          d = tbl_when[s] - {1'b0, c.now};
          if (d != 64'd0 && !d[63]) begin
            waiting = 1'b1;
            break;
          end
          awaited.push_back(reply(stq_pkg::ST_OK, 1'b1, s[3:0], tbl_gen[s], 32'd0, 1'b0));
          tbl_used[s] = 1'b0;
          void'(order.pop_front());
        end
        if (!waiting) ms = {32'd0, stq_pkg::MS_NONE};
        else begin
          ms = (d + 64'd9999) / 64'd10000;
          if (ms > {32'd0, stq_pkg::MS_CAP}) ms = {32'd0, stq_pkg::MS_CAP};
        end
        awaited.push_back(reply(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, ms[31:0], 1'b1));
      end
      default: awaited.push_back(reply(stq_pkg::ST_INVAL, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1));
    endcase
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Driver: offer queued items, hold each until accepted, idle at random.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the offered item
    end else begin
      if (in_ch.valid) predict_results(in_ch.data);
      if (send_gap > 0 || pending_cmds.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_ch.data  <= pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        send_gap = gap_len();
      end
    end
  end

  // Receiver back-pressure: one long hold-off, armed once the directed items
  // have partly drained, counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (!stall_done && pending_cmds.size() > 0 && pending_cmds.size() < 12) begin
      hold_off   <= 400;
      stall_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  int recv_gap = 0;
  always @(posedge clk) begin
    stq_pkg::out_item_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (awaited.size() == 0) report("result with nothing awaited");
        else begin
          want = awaited.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.is_expired !== want.is_expired)
            report($sformatf("is_expired %0b, want %0b", got.is_expired, want.is_expired));
          if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", got.slot, want.slot));
          if (got.gen !== want.gen)
            report($sformatf("gen %0h, want %0h", got.gen, want.gen));
          if (got.next_ms !== want.next_ms)
            report($sformatf("next_ms %0h, want %0h", got.next_ms, want.next_ms));
          if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
      if (hold_off > 0) out_ch.ready <= 1'b0;
      else if (recv_gap > 0) begin
        out_ch.ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = gap_len();
      end
    end
  end

  function automatic stq_pkg::in_item_t make_cmd(input logic [1:0] op,
                                                 input logic [63:0] tmo,
                                                 input logic [62:0] t_now, input logic hp,
                                                 input logic [3:0] hs,
                                                 input logic [31:0] hg);
    stq_pkg::in_item_t c;
    c.command = op; c.timeout = tmo; c.now = t_now;
    c.handle_present = hp; c.handle_slot = hs; c.handle_gen = hg;
    return c;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random content: noise in unused fields, recent generations for most cancels.
  function automatic stq_pkg::in_item_t random_cmd(input int live_gen_hint);
    logic [63:0] tmo;
    int pick;
    pick = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 300_000);
    if (pick < 45) begin
      case ($urandom_range(0, 5))
        0: tmo = -$signed({32'd0, $urandom_range(0, 2_000_000)});
        1: tmo = {1'b0, clock_now} + $urandom_range(1, 3_000_000);
        2: tmo = {1'b0, clock_now} - $urandom_range(0, 1_000);
        3: tmo = rand64();
        4: tmo = 64'd0;
        default: tmo = {1'b0, clock_now} + {$urandom_range(0, 9), $urandom()};
      endcase
      return make_cmd(stq_pkg::CMD_REGISTER, tmo, clock_now, 1'($urandom), 4'($urandom),
                      $urandom);
    end else if (pick < 70) begin
      // most cancels name a recent generation; the slot is a guess
      return make_cmd(stq_pkg::CMD_CANCEL, rand64(), clock_now, $urandom_range(0, 9) != 0,
                      4'($urandom), ($urandom_range(0, 4) != 0) ?
                      32'(live_gen_hint - int'($urandom_range(0, 12))) : $urandom);
    end else if (pick < 97) begin
      return make_cmd(stq_pkg::CMD_SWEEP, rand64(), clock_now, 1'($urandom), 4'($urandom),
                      $urandom);
    end
    return make_cmd(stq_pkg::CMD_RESERVED, rand64(), 63'({$urandom, $urandom}),
                    1'($urandom), 4'($urandom), $urandom);
  endfunction

  initial begin
    int gen_guess;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty sweep, null handle, unknown command, full table,
    // equal expiry times, extreme timeouts and now, cancel twice, wrap.
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_SWEEP, '0, '0, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_CANCEL, '0, '0, 1'b0, 4'hF, '1));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_RESERVED, '1, '1, 1'b1, 4'hF, '1));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_CANCEL, '0, '0, 1'b1, 4'd0, 32'd1));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'h7FFF_FFFF_FFFF_FFFF, '0,
                                    1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'h8000_0000_0000_0000, '1,
                                    1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'd0, 63'd500, 1'b1, 4'hF, '1));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'd500, 63'd0, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'd1, 63'd0, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, '1, 63'd100, 1'b0, 4'd0, 32'd0));
    for (int i = 0; i < 11; i++)
      pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'd30_000 + 64'(i), 63'd0,
                                      1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_REGISTER, 64'd5, 63'd0, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_CANCEL, '0, '0, 1'b1, 4'd3, 32'd4));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_CANCEL, '0, '0, 1'b1, 4'd3, 32'd4));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_SWEEP, '0, 63'd30_005, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_SWEEP, '0, 63'd0, 1'b0, 4'd0, 32'd0));
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_SWEEP, '0, '1, 1'b0, 4'd0, 32'd0));

    gen_guess = 20;
    for (int i = 0; i < 200; i++) begin
      pending_cmds.push_back(random_cmd(gen_guess));
      if (pending_cmds[$].command == stq_pkg::CMD_REGISTER) gen_guess++;
      if (pending_cmds.size() > 8) wait (pending_cmds.size() <= 4);
    end
    pending_cmds.push_back(make_cmd(stq_pkg::CMD_SWEEP, '0, '1, 1'b0, 4'd0, 32'd0));
    wait (pending_cmds.size() == 0 && !in_ch.valid);
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done && awaited.size() == 0 || cycle_count >= CYCLE_LIMIT);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_timer_queue_test: done, errors");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      if (error_count == 0 && awaited.size() == 0) begin
        $display("sorted_timer_queue_test: done, clean");
      end else begin
        $display("sorted_timer_queue_test: done, errors");
      end
      $finish;
    end
  end
endmodule
